[sv/clfd_pkg.sv]
// ----------------------------------------------------------------------------
// clfd_pkg
// Types and constants shared by the chunked length-field deframer.
// ----------------------------------------------------------------------------
package clfd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_done;
    logic       status;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_DATA,
    PH_CLEN,
    PH_DIGITS,
    PH_RAW,
    PH_CDATA
  } phase_t;

  localparam logic [7:0] LEAD_EMPTY_LO = 8'h00;
  localparam logic [7:0] LEAD_EMPTY_HI = 8'hFF;
  localparam logic [7:0] LEAD_CHUNKED  = 8'hFE;

  localparam int unsigned SB4_SIGN_BIT = 7;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  localparam logic CFG_IDX_SB4 = 1'b0;

endpackage

[sv/clfd_decoder.sv]
// ----------------------------------------------------------------------------
// clfd_decoder
// Field state machine and result register: one byte is decoded per beat.
// ----------------------------------------------------------------------------
module clfd_decoder import clfd_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      chunk_length_sb4,
  input  logic      item_valid,
  input  in_item_t  item,
  input  logic      advance,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int LenW = 8 * MAX_LENGTH_BYTES;
  localparam int DigW = $clog2(MAX_LENGTH_BYTES + 1);

  phase_t              phase, phase_next;
  logic [LenW-1:0]     remaining_bytes, remaining_bytes_next;
  logic [DigW-1:0]     length_digits_left, length_digits_left_next;
  logic                length_negative, length_negative_next;
  logic [LenW-1:0]     length_accumulator, length_accumulator_next;

  logic                step;
  logic                emit;
  out_item_t           res;
  logic                do_chunk;
  logic                do_error;
  logic [LenW-1:0]     chunk_len;
  logic [LenW-1:0]     rem_dec;
  logic [LenW-1:0]     acc_shift;
  logic [DigW-1:0]     dig_dec;
  logic [6:0]          sb4_width;

  assign step      = item_valid && advance;
  assign rem_dec   = remaining_bytes - LenW'(1);
  assign acc_shift = (length_accumulator << 8) | LenW'(item.in_byte);
  assign dig_dec   = length_digits_left - DigW'(1);
  assign sb4_width = item.in_byte[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LEAD;
      remaining_bytes    <= '0;
      length_digits_left <= '0;
      length_negative    <= 1'b0;
      length_accumulator <= '0;
    end else if (step) begin
      phase              <= phase_next;
      remaining_bytes    <= remaining_bytes_next;
      length_digits_left <= length_digits_left_next;
      length_negative    <= length_negative_next;
      length_accumulator <= length_accumulator_next;
    end
  end

  always_comb begin
    phase_next              = phase;
    remaining_bytes_next    = remaining_bytes;
    length_digits_left_next = length_digits_left;
    length_negative_next    = length_negative;
    length_accumulator_next = length_accumulator;
    emit                    = 1'b0;
    res                     = '0;
    do_chunk                = 1'b0;
    do_error                = 1'b0;
    chunk_len               = '0;

    if (item.buffer_end) begin
      do_error = 1'b1;
    end else begin
      unique case (phase)
        PH_DATA: begin
          emit           = 1'b1;
          res.out_byte   = item.in_byte;
          res.byte_valid = 1'b1;
          if (rem_dec == '0) begin
            res.field_done          = 1'b1;
            res.status              = ST_OK;
            phase_next              = PH_LEAD;
            remaining_bytes_next    = '0;
            length_digits_left_next = '0;
            length_negative_next    = 1'b0;
            length_accumulator_next = '0;
          end else begin
            remaining_bytes_next = rem_dec;
          end
        end
        PH_CDATA: begin
          emit                 = 1'b1;
          res.out_byte         = item.in_byte;
          res.byte_valid       = 1'b1;
          remaining_bytes_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_CLEN;
          end
        end
        PH_CLEN: begin
          if (!chunk_length_sb4) begin
            do_chunk  = 1'b1;
            chunk_len = LenW'(item.in_byte);
          end else begin
            length_negative_next = item.in_byte[SB4_SIGN_BIT];
            if (sb4_width > 7'(MAX_LENGTH_BYTES)) begin
              phase_next = PH_RAW;
            end else if (sb4_width == '0) begin
              do_chunk = 1'b1;
            end else begin
              length_digits_left_next = DigW'(sb4_width);
              length_accumulator_next = '0;
              phase_next              = PH_DIGITS;
            end
          end
        end
        PH_RAW: begin
          if (item.in_byte != '0) begin
            do_error = 1'b1;
          end else begin
            do_chunk = 1'b1;
          end
        end
        PH_DIGITS: begin
          length_accumulator_next = acc_shift;
          length_digits_left_next = dig_dec;
          if (dig_dec == '0) begin
            if (length_negative && acc_shift != '0) begin
              do_error = 1'b1;
            end else begin
              do_chunk  = 1'b1;
              chunk_len = acc_shift;
            end
          end
        end
        default: begin
          phase_next              = PH_LEAD;
          remaining_bytes_next    = '0;
          length_digits_left_next = '0;
          length_negative_next    = 1'b0;
          length_accumulator_next = '0;
          if (item.in_byte == LEAD_EMPTY_LO || item.in_byte == LEAD_EMPTY_HI) begin
            emit           = 1'b1;
            res.field_done = 1'b1;
            res.status     = ST_OK;
          end else if (item.in_byte == LEAD_CHUNKED) begin
            phase_next = PH_CLEN;
          end else begin
            remaining_bytes_next = LenW'(item.in_byte);
            phase_next           = PH_DATA;
          end
        end
      endcase
    end

    if (do_error || do_chunk) begin
      remaining_bytes_next    = '0;
      length_digits_left_next = '0;
      length_negative_next    = 1'b0;
      length_accumulator_next = '0;
    end

    if (do_error) begin
      phase_next     = PH_LEAD;
      emit           = 1'b1;
      res            = '0;
      res.field_done = 1'b1;
      res.status     = ST_ERROR;
    end else if (do_chunk) begin
      if (chunk_len == '0) begin
        phase_next     = PH_LEAD;
        emit           = 1'b1;
        res.field_done = 1'b1;
        res.status     = ST_OK;
      end else begin
        remaining_bytes_next = chunk_len;
        phase_next           = PH_CDATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  a_no_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.field_done)
    else $error("result beat carries neither byte nor field end");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.field_done)
    else $error("error status without field end");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.out_byte == '0)
    else $error("out_byte not cleared on a beat without payload");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA || phase == PH_CDATA |-> remaining_bytes != '0)
    else $error("payload phase with zero bytes left");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DIGITS |-> length_digits_left != '0)
    else $error("length digit phase with no digits left");

endmodule

[sv/chunked_length_field_deframer.sv]
// ----------------------------------------------------------------------------
// chunked_length_field_deframer
// Deframes length-prefixed and chunked fields from a byte stream.
//
//   channel  signals                        dir  beat
//   in       in_valid/in_ready/in_data      in   one stream byte or end mark
//   out      out_valid/out_ready/out_data   out  payload byte and/or field end
//   cfg      psel/penable/pwrite/paddr/...  in   reg 0: chunk_length_sb4
//
// One input beat per cycle while out is not stalled; each beat passes the input
// register, then one decode pass into the result register.
// The field state machine updates once per byte in a single pass.
// Reset is synchronous; it clears the state machine and sets sb4 coding.
// A stall on out holds the result; the input register keeps one more beat.
// ----------------------------------------------------------------------------
module chunked_length_field_deframer import clfd_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     chunk_length_sb4;
  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;

  assign pready  = 1'b1;
  assign advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_length_sb4 <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_SB4) begin
      chunk_length_sb4 <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_SB4) begin
      prdata[0] = chunk_length_sb4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_item <= in_data;
    end
  end

  clfd_decoder #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_decoder (
    .clk             (clk),
    .rst             (rst),
    .chunk_length_sb4(chunk_length_sb4),
    .item_valid      (s1_valid),
    .item            (s1_item),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_data        (out_data)
  );

endmodule

[verif/chunked_length_field_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_length_field_deframer_tb
// Drives encoded byte beats into the deframer and checks every output beat
// against a cycle-free model of the field decoder. The run covers both chunk
// length codings, empty, fixed and chunked fields, negative and raw lengths,
// and input that ends inside a field. Random idles are added on both sides,
// one long output stall fills the block, and a later stretch has no idles.
// ----------------------------------------------------------------------------
module chunked_length_field_deframer_tb;
  import clfd_pkg::*;

  localparam int MAX_LEN = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [2:0] SB4_ADDR = {CFG_IDX_SB4, 2'b00};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chunked_length_field_deframer #(
    .MAX_LENGTH_BYTES(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  in_item_t  stream_bytes[$];
  in_item_t  field_buf[$];
  out_item_t deframed_due[$];

  int  fails = 0;
  int  quiet_cycles = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;
  logic in_fire = 1'b0;

  // decoder model state
  logic        cfg_sb4;
  phase_t      st_phase;
  logic [31:0] st_left;
  logic [31:0] st_acc;
  logic [2:0]  st_digits;
  logic        st_neg;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_len();
    st_left = '0;
    st_digits = '0;
    st_neg = 1'b0;
    st_acc = '0;
  endfunction

  // returns 1 when a zero length closes the chunked field
  function automatic bit chunk_len_done(logic [31:0] len);
    clear_len();
    if (len == 0) begin
      st_phase = PH_LEAD;
      return 1'b1;
    end
    st_left = len;
    st_phase = PH_CDATA;
    return 1'b0;
  endfunction

  function automatic void deframe_beat(in_item_t it);
    out_item_t  res;
    bit         has;
    bit         fail;
    bit         fin;
    logic [7:0] b;
    res = '0;
    has = 1'b0;
    fail = 1'b0;
    fin = 1'b0;
    b = it.in_byte;
    if (it.buffer_end) begin
      fail = 1'b1;
    end else begin
      case (st_phase)
        PH_DATA: begin
          st_left = st_left - 1;
          res.out_byte = b;
          res.byte_valid = 1'b1;
          has = 1'b1;
          if (st_left == 0) begin
            clear_len();
            st_phase = PH_LEAD;
            fin = 1'b1;
          end
        end
        PH_CDATA: begin
          st_left = st_left - 1;
          res.out_byte = b;
          res.byte_valid = 1'b1;
          has = 1'b1;
          if (st_left == 0) st_phase = PH_CLEN;
        end
        PH_CLEN: begin
          if (!cfg_sb4) begin
            fin = chunk_len_done({24'h0, b});
          end else begin
            st_neg = b[SB4_SIGN_BIT];
            if (b[6:0] > MAX_LEN) begin
              st_phase = PH_RAW;
            end else if (b[6:0] == 0) begin
              fin = chunk_len_done('0);
            end else begin
              st_digits = b[2:0];
              st_acc = '0;
              st_phase = PH_DIGITS;
            end
          end
        end
        PH_RAW: begin
          if (b != 0) fail = 1'b1;
          else fin = chunk_len_done('0);
        end
        PH_DIGITS: begin
          st_acc = {st_acc[23:0], b};
          st_digits = st_digits - 1;
          if (st_digits == 0) begin
            if (st_neg && st_acc != 0) fail = 1'b1;
            else fin = chunk_len_done(st_acc);
          end
        end
        default: begin
          clear_len();
          st_phase = PH_LEAD;
          if (b == LEAD_EMPTY_LO || b == LEAD_EMPTY_HI) begin
            fin = 1'b1;
          end else if (b == LEAD_CHUNKED) begin
            st_phase = PH_CLEN;
          end else begin
            st_left = 32'(b);
            st_phase = PH_DATA;
          end
        end
      endcase
    end
    if (fail) begin
      clear_len();
      st_phase = PH_LEAD;
      res = '0;
      res.field_done = 1'b1;
      res.status = ST_ERROR;
      has = 1'b1;
    end else if (fin) begin
      res.field_done = 1'b1;
      res.status = ST_OK;
      has = 1'b1;
    end
    if (has) deframed_due.push_back(res);
  endfunction

  function automatic void check_beat(out_item_t got);
    out_item_t want;
    if (deframed_due.size() == 0) begin
      $error("unexpected beat: out_byte=%0h byte_valid=%0b field_done=%0b status=%0b",
             got.out_byte, got.byte_valid, got.field_done, got.status);
      fails++;
      return;
    end
    want = deframed_due.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
      fails++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
      fails++;
    end
    if (got.field_done !== want.field_done) begin
      $error("field_done: expected %0b, got %0b", want.field_done, got.field_done);
      fails++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0b, got %0b", want.status, got.status);
      fails++;
    end
  endfunction

  // input side
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (stream_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
        in_data <= stream_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      quiet_cycles <= 0;
      cfg_sb4 = 1'b1;
      st_phase = PH_LEAD;
      clear_len();
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) deframe_beat(in_data);
      if (out_valid && out_ready) check_beat(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("chunked_length_field_deframer_tb: FAIL");
        $finish;
      end
    end
  end

  // stimulus construction
  function automatic void put(logic [7:0] b);
    in_item_t it;
    it.in_byte = b;
    it.buffer_end = 1'b0;
    field_buf.push_back(it);
  endfunction

  function automatic void put_end();
    in_item_t it;
    it.in_byte = 8'($urandom);
    it.buffer_end = 1'b1;
    field_buf.push_back(it);
  endfunction

  function automatic void flush_field(int keep);
    for (int i = 0; i < keep; i++) stream_bytes.push_back(field_buf[i]);
    field_buf.delete();
  endfunction

  function automatic void put_chunk_len(int len, bit sb4);
    int w;
    if (!sb4) begin
      put(8'(len));
    end else begin
      w = $urandom_range(1, MAX_LEN);
      put({1'b0, 7'(w)});
      for (int i = w - 1; i >= 0; i--) put(8'(len >> (8 * i)));
    end
  endfunction

  // the zero chunk that closes a chunked field, in every coding
  function automatic void put_chunk_end(bit sb4);
    int w;
    if (!sb4) begin
      put(8'h00);
    end else begin
      case ($urandom_range(0, 3))
        0: put({1'($urandom), 7'd0});
        1: begin
          w = $urandom_range(1, MAX_LEN);
          put({1'($urandom), 7'(w)});
          repeat (w) put(8'h00);
        end
        2: begin
          put({1'($urandom), 7'($urandom_range(MAX_LEN + 1, 127))});
          put(8'h00);
        end
        default: put(8'h00);
      endcase
    end
  endfunction

  function automatic void put_bad_chunk();
    int w;
    if ($urandom_range(0, 1) == 0) begin
      w = $urandom_range(1, MAX_LEN);
      put({1'b1, 7'(w)});
      repeat (w - 1) put(8'($urandom));
      put(8'($urandom_range(1, 255)));
    end else begin
      put({1'($urandom), 7'($urandom_range(MAX_LEN + 1, 127))});
      put(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void build_field(bit sb4);
    int r;
    int n;
    int len;
    field_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      put($urandom_range(0, 1) ? LEAD_EMPTY_HI : LEAD_EMPTY_LO);
    end else if (r < 40) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 253) : $urandom_range(1, 8);
      put(8'(len));
      repeat (len) put(8'($urandom));
    end else if (r < 90) begin
      put(LEAD_CHUNKED);
      n = $urandom_range(0, 3);
      repeat (n) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
        put_chunk_len(len, sb4);
        repeat (len) put(8'($urandom));
      end
      if (sb4 && r >= 80) put_bad_chunk();
      else put_chunk_end(sb4);
    end else begin
      repeat ($urandom_range(1, 3)) put(8'($urandom));
    end
  endfunction

  task automatic gen_random(int target, bit sb4);
    int count;
    int cut;
    count = 0;
    while (count < target) begin
      build_field(sb4);
      if ($urandom_range(0, 99) < 8) begin
        cut = $urandom_range(0, field_buf.size() - 1);
        field_buf = field_buf[0:cut];
        field_buf[cut].buffer_end = 1'b1;
        field_buf[cut].in_byte = 8'($urandom);
        count += cut + 1;
        flush_field(cut + 1);
      end else begin
        count += field_buf.size();
        flush_field(field_buf.size());
      end
    end
  endtask

  task automatic settle();
    while (stream_bytes.size() != 0 || in_valid || deframed_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SB4_ADDR;
    pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_sb4 = val;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(val)) begin
      $error("prdata: expected %0h, got %0h", 32'(val), prdata);
      fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_write(1'b1);
    put(LEAD_EMPTY_LO);
    put(LEAD_EMPTY_HI);
    put(8'h01);
    put(8'hA5);
    put_end();
    put(LEAD_CHUNKED);
    put(8'h01);
    put(8'h02);
    put(8'h5A);
    put(8'hC3);
    put(8'h00);
    // negative length
    put(LEAD_CHUNKED);
    put(8'h81);
    put(8'h03);
    // negative zero
    put(LEAD_CHUNKED);
    put(8'h80);
    // raw byte of zero, then raw nonzero
    put(LEAD_CHUNKED);
    put(8'hFF);
    put(8'h00);
    put(LEAD_CHUNKED);
    put(8'h05);
    put(8'h01);
    // input ends inside a fixed field
    put(8'hFD);
    put(8'h00);
    put(8'hFF);
    put_end();
    flush_field(field_buf.size());
    settle();

    cfg_write(1'b0);
    gen_random(450, 1'b0);
    settle();

    cfg_write(1'b1);
    put(8'hFD);
    repeat (253) put(8'($urandom));
    flush_field(field_buf.size());
    gen_random(540, 1'b1);
    hold_req = hold_req + 1;
    settle();

    cfg_write(1'b0);
    steady = 1'b1;
    gen_random(480, 1'b0);
    settle();
    steady = 1'b0;

    if (fails == 0) begin
      $display("chunked_length_field_deframer_tb: PASS");
    end else begin
      $display("chunked_length_field_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule
